/* hw/rtl/sc2hid_pkg.sv */
// Shared types and constants for the scancode to HID keyboard report block.
// Holds the usage ROM, the modifier scancodes and the key-list command types.
// No dependencies.
package sc2hid_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned KEY_SLOTS_DEF   = 16;
	localparam int unsigned REPORT_KEYS     = 6;

	localparam logic [7:0] ROLLOVER_CODE = 8'h01;
	localparam logic [7:0] OP_QUEUE      = 8'h00;

	localparam logic OPC_QUEUE = 1'b0;
	localparam logic OPC_POLL  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_NAK = 1'b1;

	// Press codes of the eight modifiers, in report bit order.
	localparam logic [15:0] MOD_CODES [8] = '{
		16'h001D, 16'h002A, 16'h0038, 16'hE05B,
		16'hE01D, 16'h0036, 16'hE038, 16'hE05C
	};

	localparam logic [7:0] USAGE_ROM [256] = '{
		8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
		8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b,
		8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c,
		8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'he0, 8'h04, 8'h16,
		8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
		8'h34, 8'h35, 8'he1, 8'h31, 8'h1d, 8'h1b, 8'h06, 8'h19,
		8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'he5, 8'h55,
		8'he2, 8'h2c, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
		8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5f,
		8'h60, 8'h61, 8'h56, 8'h5c, 8'h5d, 8'h5e, 8'h57, 8'h59,
		8'h5a, 8'h5b, 8'h62, 8'h63, 8'h46, 8'h00, 8'h64, 8'h44,
		8'h45, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e,
		8'he8, 8'he9, 8'h71, 8'h72, 8'h73, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h88, 8'h00, 8'h00, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h8a, 8'h00, 8'h8b, 8'h00, 8'h89, 8'he7, 8'h65,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h58, 8'he4, 8'h00, 8'h00,
		8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81, 8'h00,
		8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h54, 8'h00, 8'h46,
		8'he6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h48, 8'h48, 8'h4a,
		8'h52, 8'h4b, 8'h00, 8'h50, 8'h00, 8'h4f, 8'h00, 8'h4d,
		8'h51, 8'h4e, 8'h49, 8'h4c, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'he3, 8'he7, 8'h65, 8'h66, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Command from the sequencer to the held-key list.
	typedef struct packed {
		logic       start;
		logic       release_key;
		logic [7:0] usage;
	} key_cmd_t;

	typedef logic [REPORT_KEYS-1:0][7:0] report_keys_t;

endpackage

/* hw/rtl/sc2hid_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sc2hid_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/sc2hid_keys.sv */
// Held-key list with a one-compare-per-cycle search, add and swap-remove.
// Depends on sc2hid_pkg.
module sc2hid_keys #(
	parameter int unsigned KEY_SLOTS = sc2hid_pkg::KEY_SLOTS_DEF,
	localparam int unsigned KW = $clog2(KEY_SLOTS),
	localparam int unsigned CW = $clog2(KEY_SLOTS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sc2hid_pkg::key_cmd_t      cmd,
	output logic                      done,
	output logic [CW-1:0]             count,
	output sc2hid_pkg::report_keys_t  slots
);

	localparam logic [1:0] K_IDLE = 2'd0;
	localparam logic [1:0] K_SCAN = 2'd1;
	localparam logic [1:0] K_MOVE = 2'd2;

	localparam logic [CW-1:0] FULL = CW'(KEY_SLOTS);

	logic [1:0]    state_q;
	logic [7:0]    held_q [KEY_SLOTS];
	logic [CW-1:0] count_q;
	logic [KW-1:0] idx_q;
	logic [KW-1:0] pos_q;
	logic [7:0]    usage_q;
	logic          release_q;
	logic          done_q;
	logic [7:0]    rd_key;
	logic          match;
	logic [KW-1:0] last_idx;

	assign rd_key   = held_q[idx_q];
	assign match    = (rd_key == usage_q);
	assign last_idx = KW'(count_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= K_IDLE;
			count_q   <= '0;
			done_q    <= 1'b0;
			idx_q     <= '0;
			pos_q     <= '0;
			usage_q   <= '0;
			release_q <= 1'b0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				held_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				K_IDLE: begin
					// Empty list: a press adds at slot zero, a release does nothing.
					done_q <= cmd.start && (count_q == '0);
					if (cmd.start) begin
						usage_q   <= cmd.usage;
						release_q <= cmd.release_key;
						if (count_q == '0) begin
							if (!cmd.release_key) begin
								held_q[0] <= cmd.usage;
								count_q   <= CW'(1);
							end
						end else begin
							idx_q   <= last_idx;
							state_q <= K_SCAN;
						end
					end
				end
				K_SCAN: begin
					done_q <= match ? !release_q : (idx_q == '0);
					if (match) begin
						if (release_q) begin
							pos_q   <= idx_q;
							idx_q   <= last_idx;
							state_q <= K_MOVE;
						end else begin
							state_q <= K_IDLE;
						end
					end else if (idx_q == '0) begin
						if (!release_q && count_q < FULL) begin
							held_q[KW'(count_q)] <= usage_q;
							count_q              <= count_q + CW'(1);
						end
						state_q <= K_IDLE;
					end else begin
						idx_q <= idx_q - KW'(1);
					end
				end
				K_MOVE: begin
					// The last entry fills the hole and the last slot is cleared.
					// When the hole is the last slot itself, it is only cleared.
					if (pos_q != idx_q) begin
						held_q[pos_q] <= rd_key;
					end
					held_q[idx_q] <= '0;
					count_q       <= count_q - CW'(1);
					done_q        <= 1'b1;
					state_q       <= K_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= K_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		for (int j = 0; j < sc2hid_pkg::REPORT_KEYS; j++) begin
			slots[j] = held_q[j];
		end
	end

	assign done  = done_q;
	assign count = count_q;

endmodule

/* hw/rtl/scancode_to_hid_keyboard_report_top.sv */
// Scancode to HID boot keyboard report: event queue, sequencer and report register.
// One transaction at a time: a queued event is taken every cycle unless a poll is in flight;
// a poll blocks input until its report is taken. A poll on an empty queue answers in the next
// cycle. A poll drains the queue, reading and evaluating each event in turn; non-modifier keys
// go through the key-list search, then the report is loaded. Reset clears control state and the
// key list, not the queue RAM. Depends on sc2hid_pkg, sc2hid_ram and sc2hid_keys.
module scancode_to_hid_keyboard_report_top #(
	parameter int unsigned QUEUE_DEPTH = sc2hid_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned KEY_SLOTS   = sc2hid_pkg::KEY_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [7:0] first_byte,
	input  logic [7:0] second_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       poll_status,
	output logic [7:0] report_modifiers,
	output logic [7:0] report_key_0,
	output logic [7:0] report_key_1,
	output logic [7:0] report_key_2,
	output logic [7:0] report_key_3,
	output logic [7:0] report_key_4,
	output logic [7:0] report_key_5
);

	localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned KCW = $clog2(KEY_SLOTS + 1);

	localparam logic [QCW-1:0] Q_FULL   = QCW'(QUEUE_DEPTH);
	localparam logic [QCW:0]   Q_DEPTH  = (QCW + 1)'(QUEUE_DEPTH);
	localparam logic [QAW-1:0] Q_LAST   = QAW'(QUEUE_DEPTH - 1);
	localparam logic [KCW-1:0] RPT_KEYS = KCW'(sc2hid_pkg::REPORT_KEYS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_QRD    = 3'd1;
	localparam logic [2:0] S_QEVAL  = 3'd2;
	localparam logic [2:0] S_KEYS   = 3'd3;
	localparam logic [2:0] S_REPORT = 3'd4;

	logic [2:0]     state_q;
	logic [QAW-1:0] head_q;
	logic [QCW-1:0] qcount_q;
	logic [7:0]     mods_q;
	logic           out_valid_q;
	logic           status_q;
	logic [7:0]     rep_mods_q;
	sc2hid_pkg::report_keys_t rep_keys_q;

	logic           accept;
	logic [15:0]    new_code;
	logic [QAW-1:0] head_inc;
	logic [QCW:0]   tail_sum;
	logic [QAW-1:0] wr_addr;
	logic           q_we;
	logic           q_re;
	logic [15:0]    ev_code;
	logic [15:0]    ev_press;
	logic           mod_hit;
	logic [7:0]     mod_mask;
	logic [7:0]     rom_idx;

	sc2hid_pkg::key_cmd_t     key_cmd;
	logic                     key_done;
	logic [KCW-1:0]           key_count;
	sc2hid_pkg::report_keys_t key_slots;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign accept   = in_valid && in_ready;

	assign new_code = (first_byte != 8'h00 && second_byte != 8'h00)
		? {first_byte, second_byte} : {8'h00, first_byte};

	assign head_inc = (head_q == Q_LAST) ? '0 : head_q + QAW'(1);
	assign tail_sum = (QCW + 1)'(head_q) + (QCW + 1)'(qcount_q);

	// On a full queue the oldest slot is overwritten and the head moves on.
	always_comb begin
		if (qcount_q >= Q_FULL) begin
			wr_addr = head_q;
		end else if (tail_sum >= Q_DEPTH) begin
			wr_addr = QAW'(tail_sum - Q_DEPTH);
		end else begin
			wr_addr = QAW'(tail_sum);
		end
	end

	assign q_we = accept && (opcode == sc2hid_pkg::OPC_QUEUE);
	assign q_re = (state_q == S_QRD);

	sc2hid_ram #(
		.WIDTH(16),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (wr_addr),
		.wdata (new_code),
		.re    (q_re),
		.raddr (head_q),
		.rdata (ev_code)
	);

	// Release codes are the press codes with bit 7 set.
	assign ev_press = {ev_code[15:8], 1'b0, ev_code[6:0]};

	always_comb begin
		mod_mask = '0;
		for (int m = 0; m < 8; m++) begin
			mod_mask[m] = (ev_press == sc2hid_pkg::MOD_CODES[m]);
		end
		mod_hit = (mod_mask != '0);
	end

	assign rom_idx = {(ev_code[15:8] != 8'h00), ev_code[6:0]};

	always_comb begin
		key_cmd.start       = (state_q == S_QEVAL) && !mod_hit;
		key_cmd.release_key = ev_code[7];
		key_cmd.usage       = sc2hid_pkg::USAGE_ROM[rom_idx];
	end

	sc2hid_keys #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (key_cmd),
		.done   (key_done),
		.count  (key_count),
		.slots  (key_slots)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			qcount_q    <= '0;
			mods_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == sc2hid_pkg::OPC_QUEUE) begin
							if (qcount_q >= Q_FULL) begin
								head_q <= head_inc;
							end else begin
								qcount_q <= qcount_q + QCW'(1);
							end
						end else if (qcount_q == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_QRD;
						end
					end
				end
				S_QRD: begin
					head_q   <= head_inc;
					qcount_q <= qcount_q - QCW'(1);
					state_q  <= S_QEVAL;
				end
				S_QEVAL: begin
					if (mod_hit) begin
						if (ev_code[7]) begin
							mods_q <= mods_q & ~mod_mask;
						end else begin
							mods_q <= mods_q | mod_mask;
						end
						state_q <= (qcount_q == '0) ? S_REPORT : S_QRD;
					end else begin
						state_q <= S_KEYS;
					end
				end
				S_KEYS: begin
					if (key_done) begin
						state_q <= (qcount_q == '0) ? S_REPORT : S_QRD;
					end
				end
				S_REPORT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; loaded only when a new transaction is made ready.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && opcode == sc2hid_pkg::OPC_POLL
				&& qcount_q == '0) begin
			status_q   <= sc2hid_pkg::STATUS_NAK;
			rep_mods_q <= '0;
			rep_keys_q <= '0;
		end else if (state_q == S_REPORT) begin
			status_q   <= sc2hid_pkg::STATUS_OK;
			rep_mods_q <= mods_q;
			for (int j = 0; j < sc2hid_pkg::REPORT_KEYS; j++) begin
				rep_keys_q[j] <= (key_count > RPT_KEYS) ? sc2hid_pkg::ROLLOVER_CODE
					: key_slots[j];
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign poll_status      = status_q;
	assign report_modifiers = rep_mods_q;
	assign report_key_0     = rep_keys_q[0];
	assign report_key_1     = rep_keys_q[1];
	assign report_key_2     = rep_keys_q[2];
	assign report_key_3     = rep_keys_q[3];
	assign report_key_4     = rep_keys_q[4];
	assign report_key_5     = rep_keys_q[5];

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for scancode_to_hid_keyboard_report_top: directed rows, then random
// key traffic, checked against a behavioral model of the event queue and held-key list.
// Depends on sc2hid_pkg and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QDEPTH       = sc2hid_pkg::QUEUE_DEPTH_DEF;
	localparam int unsigned KSLOTS       = sc2hid_pkg::KEY_SLOTS_DEF;
	localparam int unsigned REPORT_KEYS  = sc2hid_pkg::REPORT_KEYS;
	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned MAX_GAP      = 14;
	localparam int unsigned HOLD_AT      = 60;
	localparam int unsigned HOLD_OFF     = 600;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam int unsigned DUE_DEPTH    = 16;
	localparam int unsigned MAX_PRESSED  = 40;
	localparam int          N_ROWS       = 25;

	localparam logic       OPC_QUEUE     = sc2hid_pkg::OPC_QUEUE;
	localparam logic       OPC_POLL      = sc2hid_pkg::OPC_POLL;
	localparam logic       STATUS_OK     = sc2hid_pkg::STATUS_OK;
	localparam logic       STATUS_NAK    = sc2hid_pkg::STATUS_NAK;
	localparam logic [7:0] ROLLOVER_CODE = sc2hid_pkg::ROLLOVER_CODE;

	typedef struct packed {
		logic                     status;
		logic [7:0]               mods;
		sc2hid_pkg::report_keys_t keys;
	} kbd_report_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  reps;
		logic        typed;
		kbd_report_t want;
	} stim_row_t;

	localparam kbd_report_t NO_WANT = '0;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       opcode = OPC_QUEUE;
	logic [7:0] first_byte = 8'h00;
	logic [7:0] second_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       poll_status;
	logic [7:0] report_modifiers;
	logic [7:0] report_key_0, report_key_1, report_key_2;
	logic [7:0] report_key_3, report_key_4, report_key_5;

	// Model of the keyboard state.
	logic [15:0] ev_ring [QDEPTH];
	int unsigned ev_head, ev_count;
	logic [7:0]  mod_state;
	logic [7:0]  held [KSLOTS];
	int unsigned held_n;

	// Expected reports, written at the input and read at the output, in order.
	kbd_report_t due_list [DUE_DEPTH];
	int unsigned due_wr = 0;
	int unsigned due_rd = 0;
	logic [15:0] pressed_codes [MAX_PRESSED];
	int unsigned n_pressed = 0;
	int unsigned poll_pct, press_pct;
	int unsigned n_errors = 0;
	stim_row_t   dir_rows [N_ROWS];

	scancode_to_hid_keyboard_report_top #(
		.QUEUE_DEPTH(QDEPTH),
		.KEY_SLOTS(KSLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.first_byte(first_byte),
		.second_byte(second_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.poll_status(poll_status),
		.report_modifiers(report_modifiers),
		.report_key_0(report_key_0),
		.report_key_1(report_key_1),
		.report_key_2(report_key_2),
		.report_key_3(report_key_3),
		.report_key_4(report_key_4),
		.report_key_5(report_key_5)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(string what, int got, int want);
		n_errors++;
		$display("%0t ns mismatch in %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	function automatic void apply_key_event(logic [15:0] code);
		logic [7:0] rom_idx;
		logic [7:0] usage;
		int         pos;
		for (int m = 0; m < 8; m++) begin
			if (code == (sc2hid_pkg::MOD_CODES[m] | 16'h0080)) begin
				mod_state[m] = 1'b0;
				return;
			end
			if (code == sc2hid_pkg::MOD_CODES[m]) begin
				mod_state[m] = 1'b1;
				return;
			end
		end
		rom_idx = {code[15:8] != 8'h00, code[6:0]};
		usage = sc2hid_pkg::USAGE_ROM[rom_idx];
		pos = -1;
		// The match nearest the end of the list wins.
		for (int i = int'(held_n) - 1; i >= 0; i--) begin
			if (held[i] == usage) begin
				pos = i;
				break;
			end
		end
		if (code[7]) begin
			if (pos >= 0) begin
				held_n--;
				held[pos] = held[held_n];
				held[held_n] = 8'h00;
			end
		end else if (pos < 0 && held_n < KSLOTS) begin
			held[held_n] = usage;
			held_n++;
		end
	endfunction

	// Returns 1 when the item produces a report, which is then placed in rpt.
	function automatic bit predict_keyboard(logic op, logic [7:0] b0, logic [7:0] b1,
			output kbd_report_t rpt);
		logic [15:0] code;
		rpt = '0;
		if (op == OPC_QUEUE) begin
			code = (b0 != 8'h00 && b1 != 8'h00) ? {b0, b1} : {8'h00, b0};
			if (ev_count >= QDEPTH) begin
				ev_head = (ev_head + 1) % QDEPTH;
				ev_count = QDEPTH - 1;
			end
			ev_ring[(ev_head + ev_count) % QDEPTH] = code;
			ev_count++;
			return 1'b0;
		end
		if (ev_count == 0) begin
			rpt.status = STATUS_NAK;
			return 1'b1;
		end
		while (ev_count > 0) begin
			apply_key_event(ev_ring[ev_head]);
			ev_head = (ev_head + 1) % QDEPTH;
			ev_count--;
		end
		rpt.status = STATUS_OK;
		rpt.mods = mod_state;
		for (int j = 0; j < REPORT_KEYS; j++) begin
			rpt.keys[j] = (held_n > REPORT_KEYS) ? ROLLOVER_CODE : held[j];
		end
		return 1'b1;
	endfunction

	// Idle cycles before the next transaction; every third stretch of 40 runs back to back.
	function automatic int unsigned draw_gap(int unsigned n);
		if ((n / 40) % 3 == 2) begin
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	task automatic offer_item(logic op, logic [7:0] b0, logic [7:0] b1, int unsigned gap,
			bit typed, kbd_report_t want);
		kbd_report_t rpt;
		bit          produces;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		first_byte <= b0;
		second_byte <= b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		produces = predict_keyboard(op, b0, b1, rpt);
		if (produces) begin
			due_list[due_wr % DUE_DEPTH] = typed ? want : rpt;
			due_wr++;
		end
	endtask

	// Polls at poll_pct, else mostly presses and releases of random scancodes, with modifiers and raw noise mixed in.
	task automatic make_random_item(output logic op, output logic [7:0] b0,
			output logic [7:0] b1);
		logic [15:0] code;
		int unsigned sel;
		int unsigned idx;
		op = OPC_QUEUE;
		b0 = 8'h00;
		b1 = 8'h00;
		sel = $urandom_range(0, 99);
		if (sel < poll_pct) begin
			op = OPC_POLL;
			b0 = 8'($urandom_range(0, 255));
			b1 = 8'($urandom_range(0, 255));
			return;
		end
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			b0 = 8'($urandom_range(0, 255));
			b1 = 8'($urandom_range(0, 255));
			return;
		end
		if (sel < 22) begin
			idx = $urandom_range(0, 7);
			code = sc2hid_pkg::MOD_CODES[idx] | ($urandom_range(0, 1) ? 16'h0080 : 16'h0000);
		end else if (n_pressed == 0 || $urandom_range(0, 99) < press_pct) begin
			code = {($urandom_range(0, 3) == 0) ? 8'hE0 : 8'h00, 1'b0,
				7'($urandom_range(1, 127))};
			if (n_pressed < MAX_PRESSED) begin
				pressed_codes[n_pressed] = code;
				n_pressed++;
			end
		end else begin
			idx = $urandom_range(0, n_pressed - 1);
			code = pressed_codes[idx] | 16'h0080;
			// The last entry fills the hole; the order of the pool does not matter.
			n_pressed--;
			pressed_codes[idx] = pressed_codes[n_pressed];
		end
		if (code[15:8] != 8'h00) begin
			b0 = code[15:8];
			b1 = code[7:0];
		end else begin
			b0 = code[7:0];
		end
	endtask

	initial begin : stimulus
		int unsigned n_items;
		logic        op;
		logic [7:0]  b0, b1;
		n_items = 0;
		ev_head = 0;
		ev_count = 0;
		mod_state = 8'h00;
		held_n = 0;
		for (int i = 0; i < QDEPTH; i++) begin
			ev_ring[i] = 16'h0000;
		end
		for (int i = 0; i < KSLOTS; i++) begin
			held[i] = 8'h00;
		end
		dir_rows = '{
			'{OPC_POLL,  8'h00, 8'h00, 8'd1,  1'b1, '{STATUS_NAK, 8'h00, 48'h0}},
			'{OPC_QUEUE, 8'h1D, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'hE0, 8'h5C, 8'd1,  1'b0, NO_WANT},
			'{OPC_POLL,  8'h00, 8'h00, 8'd1,  1'b1, '{STATUS_OK, 8'h81, 48'h0}},
			'{OPC_QUEUE, 8'h9D, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'hE0, 8'hDC, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h1E, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h1E, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_POLL,  8'hFF, 8'hFF, 8'd1,  1'b1, '{STATUS_OK, 8'h00, 48'h04}},
			'{OPC_POLL,  8'h00, 8'h00, 8'd1,  1'b1, '{STATUS_NAK, 8'h00, 48'h0}},
			'{OPC_QUEUE, 8'h00, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h9E, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'hFF, 8'hFF, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'hE0, 8'h48, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h48, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'hAA, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'hB0, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_POLL,  8'h00, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h02, 8'h00, 8'd17, 1'b0, NO_WANT},
			'{OPC_POLL,  8'h00, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h83, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h01, 8'hFF, 8'd1,  1'b0, NO_WANT},
			'{OPC_POLL,  8'h00, 8'h00, 8'd1,  1'b0, NO_WANT},
			'{OPC_QUEUE, 8'h00, 8'h7F, 8'd1,  1'b0, NO_WANT},
			'{OPC_POLL,  8'h00, 8'h00, 8'd1,  1'b0, NO_WANT}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// A row with a repeat count presses consecutive scancodes, which overflows the queue.
		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				offer_item(dir_rows[r].op, dir_rows[r].b0 + 8'(k), dir_rows[r].b1,
					draw_gap(n_items), dir_rows[r].typed, dir_rows[r].want);
				n_items++;
			end
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: poll_pct = 4;
					1: poll_pct = 12;
					default: poll_pct = 30;
				endcase
				case ($urandom_range(0, 2))
					0: press_pct = 35;
					1: press_pct = 60;
					default: press_pct = 85;
				endcase
			end
			make_random_item(op, b0, b1);
			offer_item(op, b0, b1, draw_gap(n_items), 1'b0, NO_WANT);
			n_items++;
		end
		in_valid <= 1'b0;

		while (due_wr != due_rd) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin : report_side
		int unsigned k;
		int unsigned n_got;
		kbd_report_t got;
		kbd_report_t want;
		n_got = 0;
		@(posedge arst_n);
		forever begin
			// One long hold-off lets the block back up and stall its input.
			k = (n_got == HOLD_AT) ? HOLD_OFF : draw_gap(n_got);
			if (k > 0) begin
				out_ready <= 1'b0;
				repeat (k) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			n_got++;
			got.status = poll_status;
			got.mods = report_modifiers;
			got.keys = {report_key_5, report_key_4, report_key_3,
				report_key_2, report_key_1, report_key_0};
			if (due_rd == due_wr) begin
				report_mismatch("result with no poll pending, status", int'(got.status), 0);
			end else begin
				want = due_list[due_rd % DUE_DEPTH];
				due_rd++;
				if (got.status !== want.status) begin
					report_mismatch("poll_status", int'(got.status), int'(want.status));
				end
				if (got.mods !== want.mods) begin
					report_mismatch("report_modifiers", int'(got.mods), int'(want.mods));
				end
				for (int j = 0; j < REPORT_KEYS; j++) begin
					if (got.keys[j] !== want.keys[j]) begin
						report_mismatch($sformatf("report_key_%0d", j), int'(got.keys[j]),
							int'(want.keys[j]));
					end
				end
			end
		end
	end

	// Ends the run when no transaction completes on either channel for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
